>>> hw/rtl/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Shared constants and types for the interval timer edge predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package pit_pkg;

    localparam int PROD_W = 94;
    localparam int CFG_W = 30;
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    // One second is 2^9 * 5^9 ns. After the shift, the scaled reciprocal of 5^9
    // gives the exact quotient for every numerator of up to 85 bits.
    localparam int TICK_SHIFT = 9;
    localparam int RECIP_SHIFT = 106;
    localparam logic [85:0] NS_RECIP =
        86'(((128'd1 << 106) + 128'd1953124) / 128'd1953125);

    localparam logic [2:0] MODE_RESET = 3'd3;
    localparam logic [16:0] RELOAD_RESET = 17'h10000;
    localparam logic [29:0] FREQ_RESET = 30'd1193182;

    typedef enum logic [1:0] {
        CFG_MODE   = 2'd0,
        CFG_RELOAD = 2'd1,
        CFG_FREQ   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_ONESHOT  = 3'd0,
        MODE_ONESHOT1 = 3'd1,
        MODE_RATE     = 3'd2,
        MODE_SQUARE   = 3'd3,
        MODE_STROBE   = 3'd4,
        MODE_STROBE1  = 3'd5,
        MODE_RATE_A   = 3'd6,
        MODE_SQUARE_A = 3'd7
    } t_mode;

endpackage

`default_nettype wire

>>> hw/rtl/pit_div.sv
// ----------------------------------------------------------------------------
// pit_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_div #(
    parameter int DW = 94,
    parameter int VW = 30,
    parameter int SW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [DW-1:0] i_num,
    input  wire logic [VW-1:0] i_div,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [DW-1:0]      o_quot,
    output logic [VW-1:0]      o_rem,
    output logic [SW-1:0]      o_side
);

    logic          r_valid [1:DW];
    logic [DW-1:0] r_num   [1:DW];
    logic [VW-1:0] r_rem   [1:DW];
    logic [SW-1:0] r_side  [1:DW];

    for (genvar k = 0; k < DW; k++) begin : g_st
        logic          v_in;
        logic [DW-1:0] num_in;
        logic [VW-1:0] rem_in;
        logic [SW-1:0] side_in;
        logic [VW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign num_in  = i_num;
            assign rem_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_valid[k];
            assign num_in  = r_num[k];
            assign rem_in  = r_rem[k];
            assign side_in = r_side[k];
        end

        assign trial = {rem_in, num_in[DW-1]};
        assign ge    = trial >= {1'b0, i_div};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= ge ? VW'(trial - {1'b0, i_div}) : trial[VW-1:0];
                r_num[k+1]  <= {num_in[DW-2:0], ge};
                r_side[k+1] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[DW];
    assign o_quot  = r_num[DW];
    assign o_rem   = r_rem[DW];
    assign o_side  = r_side[DW];

endmodule

`default_nettype wire

>>> hw/rtl/pit_output_and_next_edge_top.sv
// ----------------------------------------------------------------------------
// pit_output_and_next_edge_top
// Output level and next output edge time of one 8254-style counter channel.
// ----------------------------------------------------------------------------
// Each input word carries the current time and the load time in nanoseconds;
// each output word carries the pin level, whether another edge follows and
// its time. The input channel is i_in_valid / o_in_stall and the output
// channel o_out_valid / i_out_stall. Registers are written through
// i_cfg_we, i_cfg_idx and i_cfg_data; the user must write them only
// while no word is in flight, which the block does not enforce. Two
// bit-serial divider pipelines (64 and 94 stages) and eleven further
// stages for the multiplies, the reciprocal scaling by one second and
// the mode logic lie between acceptance and output. One word may be
// accepted in every cycle, but the whole pipeline advances together:
// when the output word is stalled every stage holds and o_in_stall is raised.
// Reset empties the pipeline and loads the registers with mode 3, a count
// of 65536 and a tick rate of 1193182 Hz.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_output_and_next_edge_top #(
    parameter int TIME_BITS = 63
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [TIME_BITS-1:0] i_now_ns,
    input  wire logic [TIME_BITS-1:0] i_load_ns,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_out_level,
    output logic                      o_edge_pending,
    output logic [TIME_BITS-1:0]      o_next_edge_ns,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [pit_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int TB = TIME_BITS;
    localparam int PW = pit_pkg::PROD_W;
    localparam logic [64:0] TMASK65 = (65'd1 << TB) - 65'd1;
    localparam logic [86:0] RECIP = {1'b0, pit_pkg::NS_RECIP};
    localparam int QW = 174 - pit_pkg::RECIP_SHIFT;

    typedef struct packed {
        logic [TB-1:0] now;
        logic [TB-1:0] load;
        logic [63:0]   d;
    } t_side2;

    typedef struct packed {
        logic [TB-1:0] now;
        logic [TB-1:0] load;
        logic          level;
        logic          pending;
    } t_side3;

    logic [2:0]  r_mode;
    logic [16:0] r_reload;
    logic [29:0] r_freq;
    logic [29:0] freq_eff;
    logic [16:0] cnt;
    logic [2:0]  mode_eff;
    logic        en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= pit_pkg::MODE_RESET;
            r_reload <= pit_pkg::RELOAD_RESET;
            r_freq   <= pit_pkg::FREQ_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pit_pkg::CFG_MODE:   r_mode   <= i_cfg_data[2:0];
                pit_pkg::CFG_RELOAD: r_reload <= i_cfg_data[16:0];
                pit_pkg::CFG_FREQ:   r_freq   <= i_cfg_data[29:0];
                default: ;
            endcase
        end
    end

    assign freq_eff = (r_freq == '0) ? 30'd1 : r_freq;
    assign cnt      = (r_reload == '0) ? 17'h10000 : r_reload;

    always_comb begin
        case (r_mode)
            pit_pkg::MODE_RATE_A:   mode_eff = pit_pkg::MODE_RATE;
            pit_pkg::MODE_SQUARE_A: mode_eff = pit_pkg::MODE_SQUARE;
            default:                mode_eff = r_mode;
        endcase
    end

    logic r_out_valid;
    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // Stage A: elapsed time.
    logic          r_a_valid;
    logic [TB-1:0] r_a_now, r_a_load;
    logic [63:0]   r_a_elap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_now  <= i_now_ns;
            r_a_load <= i_load_ns;
            r_a_elap <= (i_now_ns >= i_load_ns) ? 64'(i_now_ns - i_load_ns) : 64'd0;
        end
    end

    // Stage B: partial products of elapsed time and tick rate.
    logic          r_b_valid;
    logic [TB-1:0] r_b_now, r_b_load;
    logic [61:0]   r_b_pp0, r_b_pp1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_now  <= r_a_now;
            r_b_load <= r_a_load;
            r_b_pp0  <= 62'(r_a_elap[31:0]) * 62'(freq_eff);
            r_b_pp1  <= 62'(r_a_elap[63:32]) * 62'(freq_eff);
        end
    end

    // Stage C: full product.
    logic          r_c_valid;
    logic [TB-1:0] r_c_now, r_c_load;
    logic [PW-1:0] r_c_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_now  <= r_b_now;
            r_c_load <= r_b_load;
            r_c_prod <= PW'(r_b_pp0) + (PW'(r_b_pp1) << 32);
        end
    end

    // Stages R1 to R3: ticks = product / 1e9 by reciprocal multiplication.
    logic          r_r1_valid, r_r2_valid, r_r3_valid;
    logic [TB-1:0] r_r1_now, r_r1_load, r_r2_now, r_r2_load, r_r3_now, r_r3_load;
    logic [86:0]   x_q;
    logic [28:0]   x_limb [3];
    logic [28:0]   m_limb [3];
    logic [57:0]   r_r1_pp [3][3];
    logic [115:0]  r_r2_row [3];
    logic [173:0]  n_total;
    logic [QW-1:0] q_wide;
    logic [63:0]   r_r3_ticks;

    assign x_q = {2'b00, r_c_prod[PW-1:pit_pkg::TICK_SHIFT]};

    for (genvar gi = 0; gi < 3; gi++) begin : g_pp_row
        assign x_limb[gi] = x_q[29*gi +: 29];
        assign m_limb[gi] = RECIP[29*gi +: 29];

        for (genvar gj = 0; gj < 3; gj++) begin : g_pp_col
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_r1_pp[gi][gj] <= 58'(x_limb[gi]) * 58'(m_limb[gj]);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_r2_row[gi] <= 116'(r_r1_pp[gi][0]) + (116'(r_r1_pp[gi][1]) << 29)
                                + (116'(r_r1_pp[gi][2]) << 58);
            end
        end
    end

    assign n_total = 174'(r_r2_row[0]) + (174'(r_r2_row[1]) << 29)
                     + (174'(r_r2_row[2]) << 58);
    assign q_wide  = n_total[173:pit_pkg::RECIP_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_valid <= 1'b0;
            r_r2_valid <= 1'b0;
            r_r3_valid <= 1'b0;
        end else if (en) begin
            r_r1_valid <= r_c_valid;
            r_r2_valid <= r_r1_valid;
            r_r3_valid <= r_r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r1_now   <= r_c_now;
            r_r1_load  <= r_c_load;
            r_r2_now   <= r_r1_now;
            r_r2_load  <= r_r1_load;
            r_r3_now   <= r_r2_now;
            r_r3_load  <= r_r2_load;
            r_r3_ticks <= (|q_wide[QW-1:64]) ? '1 : q_wide[63:0];
        end
    end

    // Ticks modulo the count.
    t_side2      side2_in, side2_out;
    logic        d2_valid;
    logic [16:0] d2_rem;

    assign side2_in = '{now: r_r3_now, load: r_r3_load, d: r_r3_ticks};

    pit_div #(.DW(64), .VW(17), .SW($bits(t_side2))) u_div_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_r3_valid),
        .i_num   (r_r3_ticks),
        .i_div   (cnt),
        .i_side  (side2_in),
        .o_valid (d2_valid),
        .o_quot  (),
        .o_rem   (d2_rem),
        .o_side  (side2_out)
    );

    // Stage E: mode decode, level and edge tick.
    logic [63:0] d, base, e_cnt, e_cnt1, e_half, edge_tick;
    logic [64:0] s_cnt, s_cnt1, s_half;
    logic [16:0] half;
    logic        lvl, pend;

    assign d      = side2_out.d;
    assign base   = d - 64'(d2_rem);
    assign half   = 17'((18'(cnt) + 18'd1) >> 1);
    assign s_cnt  = {1'b0, base} + 65'(cnt);
    assign e_cnt  = s_cnt[64] ? '1 : s_cnt[63:0];
    assign s_cnt1 = {1'b0, e_cnt} + 65'd1;
    assign e_cnt1 = s_cnt1[64] ? '1 : s_cnt1[63:0];
    assign s_half = {1'b0, base} + 65'(half);
    assign e_half = s_half[64] ? '1 : s_half[63:0];

    always_comb begin
        lvl       = 1'b0;
        pend      = 1'b1;
        edge_tick = '0;
        case (mode_eff)
            pit_pkg::MODE_RATE: begin
                lvl       = (d2_rem == '0) && (d != '0);
                edge_tick = lvl ? e_cnt : e_cnt1;
            end
            pit_pkg::MODE_SQUARE: begin
                lvl       = d2_rem < half;
                edge_tick = lvl ? e_half : e_cnt;
            end
            pit_pkg::MODE_STROBE, pit_pkg::MODE_STROBE1: begin
                lvl       = d == 64'(cnt);
                pend      = d <= 64'(cnt);
                edge_tick = lvl ? 64'(cnt) + 64'd1 : 64'(cnt);
            end
            default: begin
                lvl       = d >= 64'(cnt);
                pend      = d < 64'(cnt);
                edge_tick = 64'(cnt);
            end
        endcase
    end

    logic          r_e_valid, r_e_level, r_e_pending;
    logic [TB-1:0] r_e_now, r_e_load;
    logic [63:0]   r_e_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_now     <= side2_out.now;
            r_e_load    <= side2_out.load;
            r_e_level   <= lvl;
            r_e_pending <= pend;
            r_e_edge    <= edge_tick;
        end
    end

    // Stage F: partial products of edge tick and 1e9.
    logic          r_f_valid, r_f_level, r_f_pending;
    logic [TB-1:0] r_f_now, r_f_load;
    logic [61:0]   r_f_pp0, r_f_pp1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_now     <= r_e_now;
            r_f_load    <= r_e_load;
            r_f_level   <= r_e_level;
            r_f_pending <= r_e_pending;
            r_f_pp0     <= 62'(r_e_edge[31:0]) * 62'(pit_pkg::NS_PER_SEC);
            r_f_pp1     <= 62'(r_e_edge[63:32]) * 62'(pit_pkg::NS_PER_SEC);
        end
    end

    // Stage G: full product.
    logic          r_g_valid;
    t_side3        r_g_side;
    logic [PW-1:0] r_g_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (en) begin
            r_g_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_side <= '{now: r_f_now, load: r_f_load, level: r_f_level,
                          pending: r_f_pending};
            r_g_prod <= PW'(r_f_pp0) + (PW'(r_f_pp1) << 32);
        end
    end

    // Edge offset in nanoseconds = product / tick rate.
    t_side3        side3_out;
    logic          d3_valid;
    logic [PW-1:0] d3_quot;
    logic [63:0]   ofs;
    logic [64:0]   t_sum;

    pit_div #(.DW(PW), .VW(30), .SW($bits(t_side3))) u_div_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_g_valid),
        .i_num   (r_g_prod),
        .i_div   (freq_eff),
        .i_side  (r_g_side),
        .o_valid (d3_valid),
        .o_quot  (d3_quot),
        .o_rem   (),
        .o_side  (side3_out)
    );

    assign ofs   = (|d3_quot[PW-1:64]) ? '1 : d3_quot[63:0];
    assign t_sum = 65'(side3_out.load) + 65'(ofs);

    // Stage H: saturated edge time.
    logic          r_h_valid, r_h_level, r_h_pending;
    logic [TB-1:0] r_h_now, r_h_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (en) begin
            r_h_valid <= d3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_now     <= side3_out.now;
            r_h_level   <= side3_out.level;
            r_h_pending <= side3_out.pending;
            r_h_t       <= (t_sum > TMASK65) ? '1 : t_sum[TB-1:0];
        end
    end

    // Output stage: pending edge >= now + 1 ns, or now if now is all ones.
    logic [TB-1:0] n_next;
    logic          r_out_level, r_out_pending;
    logic [TB-1:0] r_out_next;

    always_comb begin
        if (!r_h_pending) begin
            n_next = '0;
        end else if (r_h_t <= r_h_now) begin
            n_next = (r_h_now != '1) ? r_h_now + TB'(1) : r_h_now;
        end else begin
            n_next = r_h_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_level   <= r_h_level;
            r_out_pending <= r_h_pending;
            r_out_next    <= n_next;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_level    = r_out_level;
    assign o_edge_pending = r_out_pending;
    assign o_next_edge_ns = r_out_next;

    a_no_edge_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_edge_pending |-> o_next_edge_ns == '0)
        else $error("edge time not zero without a pending edge");

    a_edge_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_edge_pending |-> o_next_edge_ns != '0)
        else $error("pending edge reported at time zero");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output is free");

endmodule

`default_nettype wire
